/* hw/rtl/merge_sort_top_defines.svh */
// ----------------------------------------------------------------------------
// merge_sort_top_defines.svh
// Assertion macros used by the merge sort back end (msort_back).
// ----------------------------------------------------------------------------
`ifndef MERGE_SORT_TOP_DEFINES_SVH
`define MERGE_SORT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define MSORT_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define MSORT_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/msort_pkg.sv */
// ----------------------------------------------------------------------------
// msort_pkg
// Types and fixed constants shared by the merge sort front, queue and back.
// ----------------------------------------------------------------------------
package msort_pkg;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QAW         = $clog2(QUEUE_DEPTH);

    // Classification of one accepted beat
    typedef struct packed {
        logic store;    // element goes into the store
        logic close;    // beat closes the batch
        logic dropped;  // batch has dropped an element (valid with close)
    } cmd_ctrl_t;

    localparam int CTRL_W = $bits(cmd_ctrl_t);

    // Back-end sequencer
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS,
        ST_MERGE,
        ST_OUT_RD,
        ST_OUT_WR
    } sort_state_t;

endpackage

/* hw/rtl/msort_fifo.sv */
// ----------------------------------------------------------------------------
// msort_fifo
// Short command queue that decouples the front from the sort back end.
// ----------------------------------------------------------------------------
module msort_fifo
    import msort_pkg::*;
#(
    parameter int WIDTH = 35
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [0:QUEUE_DEPTH-1];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]     count_reg, count_next;

    assign full     = (count_reg == (QAW+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QAW'(push);
        rd_ptr_next = rd_ptr_reg + QAW'(pop);
        count_next  = count_reg + (QAW+1)'(push) - (QAW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/msort_front.sv */
// ----------------------------------------------------------------------------
// msort_front
// Accepts input beats, decides store or drop against capacity and tracks the
// batch overflow flag; pushes one classified command per beat.
// ----------------------------------------------------------------------------
module msort_front
    import msort_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic                         is_last,
    input  logic                         q_full,
    output logic                         q_push,
    output cmd_ctrl_t                    q_ctrl,
    output logic [DATA_WIDTH-1:0]        q_value
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          drop_reg, drop_next;
    logic          accept;
    logic          has_room;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign has_room = (cnt_reg < CW'(CAPACITY));

    // classify the beat
    always_comb
    begin
        q_push          = accept;
        q_ctrl.store    = has_room;
        q_ctrl.close    = is_last;
        q_ctrl.dropped  = drop_reg || !has_room;
        q_value         = value;
        cnt_next        = cnt_reg;
        drop_next       = drop_reg;
        if (accept)
        begin
            if (is_last)
            begin
                cnt_next  = '0;
                drop_next = 1'b0;
            end
            else
            begin
                cnt_next  = cnt_reg + CW'(has_room);
                drop_next = drop_reg || !has_room;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            drop_reg <= drop_next;
        end
    end

endmodule

/* hw/rtl/msort_back.sv */
// ----------------------------------------------------------------------------
// msort_back
// Sort engine: loads the batch into a two-bank store, runs bottom-up merge
// passes one element per cycle, then streams the sorted batch out.
// ----------------------------------------------------------------------------
`include "merge_sort_top_defines.svh"

module msort_back
    import msort_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  cmd_ctrl_t                     q_ctrl,
    input  logic [DATA_WIDTH-1:0]         q_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [DATA_WIDTH-1:0]  sorted_value,
    output logic                          last_out,
    output logic                          overflow
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int SW = CW + 2;
    localparam int MA = AW + 1;

    // two banks: merge reads one, writes the other
    logic [DATA_WIDTH-1:0] sort_mem [0:(2**MA)-1];

    sort_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          drop_reg, drop_next;
    logic          sb_reg, sb_next;
    logic [SW-1:0] w_reg, w_next;
    logic [SW-1:0] mid_reg, mid_next;
    logic [SW-1:0] hi_reg, hi_next;
    logic [SW-1:0] a_reg, a_next;
    logic [SW-1:0] b_reg, b_next;
    logic [SW-1:0] k_reg, k_next;

    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] out_value_reg, out_value_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_ovf_reg, out_ovf_next;

    logic [DATA_WIDTH-1:0] ra_reg, rb_reg;
    logic [MA-1:0]         rd_a, rd_b, mem_waddr;
    logic                  mem_we;
    logic [DATA_WIDTH-1:0] mem_wdata;

    logic [SW-1:0] n_ext, w2, sum_w, sum_2w;
    logic [SW-1:0] a_adv, b_adv, k_adv;
    logic [CW-1:0] cnt_inc;
    logic          take_a, out_take;

    assign n_ext    = SW'(n_reg);
    assign w2       = w_reg << 1;
    assign sum_w    = hi_reg + w_reg;
    assign sum_2w   = hi_reg + w2;
    assign out_take = out_valid_reg && !out_stall;
    assign cnt_inc  = cnt_reg + CW'(q_ctrl.store);

    // merge choice: left run wins ties
    assign take_a = (a_reg < mid_reg)
                    && ((b_reg >= hi_reg) || ($signed(ra_reg) <= $signed(rb_reg)));
    assign a_adv  = a_reg + SW'(take_a);
    assign b_adv  = b_reg + SW'(!take_a);
    assign k_adv  = k_reg + SW'(1);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        drop_next      = drop_reg;
        sb_next        = sb_reg;
        w_next         = w_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        rd_a           = {sb_reg, a_reg[AW-1:0]};
        rd_b           = {sb_reg, b_reg[AW-1:0]};
        out_valid_next = out_valid_reg && !out_take;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (q_ctrl.store)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = {1'b0, cnt_reg[AW-1:0]};
                        mem_wdata = q_value;
                    end
                    if (q_ctrl.close)
                    begin
                        n_next    = cnt_inc;
                        drop_next = q_ctrl.dropped;
                        cnt_next  = '0;
                        sb_next   = 1'b0;
                        w_next    = SW'(1);
                        idx_next  = '0;
                        state_next = (cnt_inc > CW'(1)) ? ST_PASS : ST_OUT_RD;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
            end

            // first merge of a pass: runs [0,w) and [w,2w), clipped to n
            ST_PASS:
            begin
                mid_next   = (w_reg < n_ext) ? w_reg : n_ext;
                hi_next    = (w2 < n_ext) ? w2 : n_ext;
                a_next     = '0;
                b_next     = mid_next;
                k_next     = '0;
                rd_a       = {sb_reg, {AW{1'b0}}};
                rd_b       = {sb_reg, mid_next[AW-1:0]};
                state_next = ST_MERGE;
            end

            // one output element per cycle into the other bank
            ST_MERGE:
            begin
                mem_we    = 1'b1;
                mem_waddr = {~sb_reg, k_reg[AW-1:0]};
                mem_wdata = take_a ? ra_reg : rb_reg;
                if (k_adv == hi_reg)
                begin
                    if (hi_reg == n_ext)
                    begin
                        sb_next    = ~sb_reg;
                        w_next     = w2;
                        idx_next   = '0;
                        state_next = (w2 < n_ext) ? ST_PASS : ST_OUT_RD;
                    end
                    else
                    begin
                        mid_next = (sum_w < n_ext) ? sum_w : n_ext;
                        hi_next  = (sum_2w < n_ext) ? sum_2w : n_ext;
                        a_next   = hi_reg;
                        b_next   = mid_next;
                        k_next   = hi_reg;
                        rd_a     = {sb_reg, hi_reg[AW-1:0]};
                        rd_b     = {sb_reg, mid_next[AW-1:0]};
                    end
                end
                else
                begin
                    a_next = a_adv;
                    b_next = b_adv;
                    k_next = k_adv;
                    rd_a   = {sb_reg, a_adv[AW-1:0]};
                    rd_b   = {sb_reg, b_adv[AW-1:0]};
                end
            end

            ST_OUT_RD:
            begin
                rd_a       = {sb_reg, idx_reg[AW-1:0]};
                state_next = ST_OUT_WR;
            end

            // read data ready; load the output register once it frees up
            ST_OUT_WR:
            begin
                rd_a = {sb_reg, idx_reg[AW-1:0]};
                if (!out_valid_reg || out_take)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = ra_reg;
                    out_last_next  = ((idx_reg + CW'(1)) == n_reg);
                    out_ovf_next   = drop_reg;
                    idx_next       = idx_reg + CW'(1);
                    state_next     = ((idx_reg + CW'(1)) == n_reg) ? ST_LOAD : ST_OUT_RD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            drop_reg      <= 1'b0;
            sb_reg        <= 1'b0;
            w_reg         <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            drop_reg      <= drop_next;
            sb_reg        <= sb_next;
            w_reg         <= w_next;
            mid_reg       <= mid_next;
            hi_reg        <= hi_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    // store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sort_mem[mem_waddr] <= mem_wdata;
        end
        ra_reg <= sort_mem[rd_a];
        rb_reg <= sort_mem[rd_b];
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = out_value_reg;
    assign last_out     = out_last_reg;
    assign overflow     = out_ovf_reg;

    // checks
    `MSORT_CHECK(a_merge_k_in_run, (state_reg == ST_MERGE), (k_reg < hi_reg), "merge write past run end")
    `MSORT_CHECK(a_merge_ptr_sum, (state_reg == ST_MERGE), ((k_reg + mid_reg) == (a_reg + b_reg)), "merge pointers out of step")
    `MSORT_CHECK(a_load_count, 1'b1, (cnt_reg <= CW'(CAPACITY)), "load count above capacity")
    `MSORT_CHECK_NEXT(a_pass_start, (state_reg == ST_PASS), ((state_reg == ST_MERGE) && (k_reg == '0)), "pass did not start at zero")

endmodule

/* hw/rtl/merge_sort_top.sv */
// ----------------------------------------------------------------------------
// merge_sort_top
// Stable streaming merge sort of one batch of signed values.
//
//   channel   dir   handshake            payload
//   input     in    in_valid / in_stall  value, is_last
//   output    out   out_valid/ out_stall sorted_value, last_out, overflow
//
// Input beats are queued and loaded one per cycle while the back end is in its
// load state. Closing a batch of n > 1 elements runs ceil(log2 n) merge passes,
// each a setup state then one element per cycle through the two-read, one-write
// store; results then leave through a read state and a write state each, as
// store reads are registered. No clearing pass after reset: store contents are
// only used where the current batch wrote them. Input stalls only when the
// queue is full; output stalls hold the result register and pause the back end.
// ----------------------------------------------------------------------------
module merge_sort_top
    import msort_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic                         is_last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] sorted_value,
    output logic                         last_out,
    output logic                         overflow
);

    localparam int QW = CTRL_W + DATA_WIDTH;

    logic                  q_push, q_full, q_pop, q_empty;
    cmd_ctrl_t             push_ctrl, pop_ctrl;
    logic [DATA_WIDTH-1:0] push_value, pop_value;
    logic [QW-1:0]         push_word, pop_word;

    assign push_word = {push_ctrl, push_value};
    assign pop_ctrl  = cmd_ctrl_t'(pop_word[QW-1:DATA_WIDTH]);
    assign pop_value = pop_word[DATA_WIDTH-1:0];

    // classify beats
    msort_front #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .value    (value),
        .is_last  (is_last),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_ctrl   (push_ctrl),
        .q_value  (push_value)
    );

    // command queue
    msort_fifo #(
        .WIDTH (QW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_word),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_word),
        .empty     (q_empty)
    );

    // load, merge, emit
    msort_back #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_ctrl       (pop_ctrl),
        .q_value      (pop_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflow     (overflow)
    );

endmodule
